### sv/gb3_pkg.sv
// ---------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur stream core.
// ---------------------------------------------------------------------------
package gb3_pkg;

  typedef logic [7:0] pix_t;

  // window[row][col]: row 0 is two rows up, col 2 is the newest column
  typedef pix_t [2:0][2:0] win_t;

  // edge replication choices and end-of-frame mark for one output
  typedef struct packed {
    logic rep_top;
    logic rep_bottom;
    logic rep_left;
    logic rep_right;
    logic last;
  } edge_flags_t;

  localparam int PIX_W   = 8;
  localparam int LINE_W  = 2 * PIX_W;   // {upper, lower} line store word
  localparam int FW_W    = 11;          // frame_width register
  localparam int FH_W    = 16;          // frame_height register
  localparam int ROW_W   = FH_W + 1;    // row count runs one past the frame in drain
  localparam int SUM_W   = 12;          // 16 * 255 fits
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

endpackage

### sv/gb3_cfg_regs.sv
// ---------------------------------------------------------------------------
// gb3_cfg_regs
// APB register file: frame width and frame height, with a restart pulse.
// ---------------------------------------------------------------------------
module gb3_cfg_regs
  import gb3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FW_W-1:0]   frame_width,
  output logic [FH_W-1:0]   frame_height,
  output logic              restart
);

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign restart = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  assign frame_width  = frame_width_r;
  assign frame_height = frame_height_r;

endmodule

### sv/gb3_line_store.sv
// ---------------------------------------------------------------------------
// gb3_line_store
// Two line buffers packed as one word per column, registered read with
// write-to-read forwarding when both hit the same column.
// ---------------------------------------------------------------------------
module gb3_line_store
  import gb3_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [LINE_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [LINE_W-1:0]        rd_data
);

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/gb3_kernel.sv
// ---------------------------------------------------------------------------
// gb3_kernel
// 1 2 1 / 2 4 2 / 1 2 1 weighted sum with edge replication, divide by 16,
// and the result register.
// ---------------------------------------------------------------------------
module gb3_kernel
  import gb3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        win_valid,
  input  win_t        win,
  input  edge_flags_t flags,
  output logic        win_take,
  output logic        out_valid,
  input  logic        out_stall,
  output pix_t        out_filtered_pixel,
  output logic        out_frame_last
);

  logic               out_valid_r;
  pix_t               pixel_r;
  logic               last_r;
  logic               out_free;
  pix_t [2:0]         row_top;
  pix_t [2:0]         row_bot;
  logic [SUM_W-1:0]   rs [3];
  logic [SUM_W-1:0]   total;
  pix_t [2:0][2:0]    rows;

  assign row_top = flags.rep_top    ? win[1] : win[0];
  assign row_bot = flags.rep_bottom ? win[1] : win[2];

  always_comb begin
    rows[0] = row_top;
    rows[1] = win[1];
    rows[2] = row_bot;
    for (int r = 0; r < 3; r++) begin
      rs[r] = SUM_W'(flags.rep_left  ? rows[r][1] : rows[r][0])
            + (SUM_W'(rows[r][1]) << 1)
            + SUM_W'(flags.rep_right ? rows[r][1] : rows[r][2]);
    end
    total = rs[0] + (rs[1] << 1) + rs[2];
  end

  assign out_free = !out_valid_r || !out_stall;
  assign win_take = win_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_take) begin
      pixel_r <= total[SUM_W-1:4];
      last_r  <= flags.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = pixel_r;
  assign out_frame_last     = last_r;

endmodule

### sv/gaussian_blur_3x3_stream_core.sv
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_stream_core
// Streaming 3x3 Gaussian blur of an 8-bit raster frame with edge replication,
// two line buffers in one line store and a drain phase after the last pixel.
//
//   port group   direction  handshake          payload
//   in_*         sink       in_valid/in_stall   in_operation, in_pixel_value
//   out_*        source     out_valid/out_stall out_filtered_pixel, out_frame_last
//   apb          slave      psel/penable        paddr, pwdata, prdata
//
// One request per clock while in_stall is low. A request is taken into the
// window register on the edge it is accepted; the window it completes moves
// on into the output register when the kernel takes it, which waits while
// the output is stalled. The line store is read ahead at the next column,
// which keeps that path at one memory port read and one write. Reset is
// synchronous and needs no clearing pass. A stalled output holds one more
// result in the window stage before in_stall rises.
// ---------------------------------------------------------------------------
module gaussian_blur_3x3_stream_core
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [7:0]        in_pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_filtered_pixel,
  output logic              out_frame_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > FW_W) ? EW : FW_W;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic              restart;
  logic [CMPW-1:0]   fw_ext;
  logic [EW-1:0]     eff_w;
  logic [FH_W-1:0]   eff_h;

  logic [CW-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CW-1:0]     tc_r, tc_nxt;
  logic [FH_W-1:0]   tr_r, tr_nxt;
  win_t              win_r, win_nxt;
  edge_flags_t       flags_r, flags_nxt;
  logic              s1_valid_r, s1_valid_nxt;

  logic              accept;
  logic              drain;
  logic              process;
  logic              out_ready;
  logic              col_wrap;
  pix_t              pix_in;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic              line_we;
  logic              win_take;
  edge_flags_t       fl;

  gb3_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart)
  );

  // effective frame size: zero acts as one, width clamps to the line store
  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (fw_ext == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext[EW-1:0];
    end
    eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  assign in_stall = s1_valid_r && !win_take;
  assign accept   = in_valid && !in_stall;
  assign drain    = row_r >= ROW_W'(eff_h);
  assign process  = accept && (drain || (in_operation != OP_DRAIN));
  assign pix_in   = drain ? '0 : in_pixel_value;

  // output becomes due once the request index reaches the effective width + 1
  assign out_ready = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
  assign col_wrap  = (EW'(col_r) + EW'(1)) >= eff_w;

  always_comb begin
    fl.rep_top    = (tr_r == '0);
    fl.rep_bottom = (ROW_W'(tr_r) + ROW_W'(1)) >= ROW_W'(eff_h);
    fl.rep_left   = (tc_r == '0);
    fl.rep_right  = (EW'(tc_r) + EW'(1)) >= eff_w;
    fl.last       = fl.rep_bottom && fl.rep_right;
  end

  // line store word: [15:8] two rows up, [7:0] one row up
  assign line_we = process && rst_n;
  assign line_wr = {line_rd[PIX_W-1:0], pix_in};

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    tc_nxt       = tc_r;
    tr_nxt       = tr_r;
    win_nxt      = win_r;
    flags_nxt    = flags_r;
    s1_valid_nxt = s1_valid_r && !win_take;
    if (process) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
      end
      win_nxt[0][2] = line_rd[LINE_W-1:PIX_W];
      win_nxt[1][2] = line_rd[PIX_W-1:0];
      win_nxt[2][2] = pix_in;
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
      if (out_ready) begin
        s1_valid_nxt = 1'b1;
        flags_nxt    = fl;
        if (fl.rep_right) begin
          tc_nxt = '0;
          tr_nxt = tr_r + FH_W'(1);
        end else begin
          tc_nxt = tc_r + CW'(1);
        end
        if (fl.last) begin
          col_nxt = '0;
          row_nxt = '0;
          tc_nxt  = '0;
          tr_nxt  = '0;
        end
      end
    end
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      tc_nxt  = '0;
      tr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      tc_r       <= '0;
      tr_r       <= '0;
      win_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      tc_r       <= tc_nxt;
      tr_r       <= tr_nxt;
      win_r      <= win_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

  // read address runs one request ahead so the word is ready on accept
  gb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (col_r),
    .wr_data (line_wr),
    .rd_addr (rst_n ? col_nxt : '0),
    .rd_data (line_rd)
  );

  gb3_kernel u_kernel (
    .clk                (clk),
    .rst_n              (rst_n),
    .win_valid          (s1_valid_r),
    .win                (win_r),
    .flags              (flags_r),
    .win_take           (win_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_pixel (out_filtered_pixel),
    .out_frame_last     (out_frame_last)
  );

endmodule

### dv/blur_checker.sv
// ---------------------------------------------------------------------------
// blur_checker
// Watches the config port and both streams of the 3x3 Gaussian blur core,
// predicts every filtered pixel and its end-of-frame mark, and compares each
// accepted output against the oldest prediction.
// ---------------------------------------------------------------------------
module blur_checker
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_operation,
  input  logic [7:0]        in_pixel_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_filtered_pixel,
  input  logic              out_frame_last,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pix_t value;
    logic last;
  } blurred_t;

  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  pix_t            upper_line [MAX_WIDTH];
  pix_t            lower_line [MAX_WIDTH];
  win_t            window;
  int unsigned     row_pos;
  int unsigned     col_pos;
  int unsigned     out_index;
  blurred_t        blurred_q [$];

  task automatic rewind_frame();
    row_pos   = 0;
    col_pos   = 0;
    out_index = 0;
  endtask

  task automatic blur_step(input logic op, input pix_t px);
    int unsigned w, h, tr, tc, r0, r2, c0, c2, sum;
    pix_t        v, top_px, mid_px;
    logic        ready;
    blurred_t    res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    // a drain request while pixels are still due does nothing
    if (row_pos < h && op == OP_DRAIN) return;
    v      = (row_pos >= h) ? 8'd0 : px;
    top_px = upper_line[col_pos];
    mid_px = lower_line[col_pos];
    upper_line[col_pos] = mid_px;
    lower_line[col_pos] = v;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = top_px;
    window[1][2] = mid_px;
    window[2][2] = v;
    ready = row_pos >= 2 || (row_pos == 1 && col_pos >= 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!ready) return;
    tr = out_index / w;
    tc = out_index % w;
    // edge replication: fall back to the center row or column
    r0 = (tr == 0) ? 1 : 0;
    r2 = (tr + 1 >= h) ? 1 : 2;
    c0 = (tc == 0) ? 1 : 0;
    c2 = (tc + 1 >= w) ? 1 : 2;
    sum = window[r0][c0] + 2 * window[r0][1] + window[r0][c2]
        + 2 * (window[1][c0] + 2 * window[1][1] + window[1][c2])
        + window[r2][c0] + 2 * window[r2][1] + window[r2][c2];
    res.value = pix_t'(sum / 16);
    res.last  = (out_index + 1 >= h * w);
    blurred_q.push_back(res);
    out_index++;
    if (res.last) rewind_frame();
  endtask

  always @(posedge clk) begin
    blurred_t want;
    if (!rst_n) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      window = '0;
      rewind_frame();
      blurred_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_FRAME_WIDTH: begin
            width_reg = pwdata[FW_W-1:0];
            rewind_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = pwdata[FH_W-1:0];
            rewind_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) blur_step(in_operation, in_pixel_value);
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $error("filtered_pixel: expected no result, actual %0d (frame_last %0b)",
                 out_filtered_pixel, out_frame_last);
          mismatches++;
        end else begin
          want = blurred_q.pop_front();
          if (out_filtered_pixel !== want.value) begin
            $error("filtered_pixel: expected %0d, actual %0d", want.value, out_filtered_pixel);
            mismatches++;
          end
          if (out_frame_last !== want.last) begin
            $error("frame_last: expected %0b, actual %0b", want.last, out_frame_last);
            mismatches++;
          end
        end
      end
    end
    pending = blurred_q.size();
  end

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the 3x3 Gaussian blur stream core: directed edge frames,
// clamped and default geometry, then random frames with noise, aborted
// frames and varying sender gaps and receiver stalls. blur_checker does the
// prediction; this module reports the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gb3_pkg::*;

  localparam int LINE_MAX       = 1024;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MODE_ITEMS     = 240;

  typedef enum {PAT_RANDOM, PAT_CHECKER, PAT_FULL} pattern_t;
  typedef enum {NOISE_NONE, NOISE_RANDOM, NOISE_FORCED} noise_t;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic              in_valid, in_stall, in_operation;
  logic [7:0]        in_pixel_value;
  logic              out_valid, out_stall, out_frame_last;
  logic [7:0]        out_filtered_pixel;
  int                chk_mismatches, chk_pending;

  int idle_pct, stall_pct, hold_req, item_count, frame_cols, frame_rows, quiet_cycles;

  gaussian_blur_3x3_stream_core #(.MAX_WIDTH(LINE_MAX)) DUT (.*);

  blur_checker #(.MAX_WIDTH(LINE_MAX)) blur_chk (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_operation, .in_pixel_value,
    .out_valid, .out_stall, .out_filtered_pixel, .out_frame_last,
    .mismatches(chk_mismatches), .pending(chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input int value);
    logic [APB_DW-1:0] data;
    data    = value;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'({idx, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      frame_cols = (data[FW_W-1:0] == 0) ? 1 :
                   ((data[FW_W-1:0] > LINE_MAX) ? LINE_MAX : data[FW_W-1:0]);
    end else begin
      frame_rows = (data[FH_W-1:0] == 0) ? 1 : data[FH_W-1:0];
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (chk_pending != 0) @(negedge clk);
    // pixels that make no output may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input logic op, input pix_t px, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = op;
    in_pixel_value = px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (counted) item_count++;
  endtask

  // one frame in raster order followed by its drain requests
  task automatic run_frame(input pattern_t pat, input noise_t noise, input int stop_after,
                           input int pause_at);
    int   total;
    pix_t px;
    total = frame_cols * frame_rows;
    for (int i = 0; i < total + frame_cols + 1; i++) begin
      if (i == stop_after) return;
      if (i == pause_at) begin
        in_valid = 1'b0;
        while (chk_pending != 0) @(negedge clk);
      end
      if (i < total) begin
        // early drain requests are ignored by the block
        if ((noise == NOISE_RANDOM && $urandom_range(9) == 0) ||
            (noise == NOISE_FORCED && i == 1))
          send_item(OP_DRAIN, pix_t'($urandom), 1'b0);
        case (pat)
          PAT_CHECKER: px = ((i % frame_cols + i / frame_cols) % 2) ? 8'hFF : 8'h00;
          PAT_FULL:    px = 8'hFF;
          default: begin
            case ($urandom_range(9))
              0:       px = 8'h00;
              1:       px = 8'hFF;
              default: px = pix_t'($urandom);
            endcase
          end
        endcase
        send_item(OP_PIXEL, px, 1'b1);
      end else begin
        // after the last pixel any request counts as drain
        if ((noise == NOISE_RANDOM && $urandom_range(2) == 0) ||
            (noise == NOISE_FORCED && i == total))
          send_item(OP_PIXEL, pix_t'($urandom), 1'b1);
        else
          send_item(OP_DRAIN, pix_t'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int mode_start, stop_at;
    bit reconfig;
    idle_mix       = '{0, 50, 0, 22};
    stall_mix      = '{0, 0, 50, 22};
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_operation   = OP_PIXEL;
    in_pixel_value = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 0;
    item_count     = 0;
    frame_cols     = FRAME_WIDTH_RST;
    frame_rows     = FRAME_HEIGHT_RST;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: a pause until all results are out, then cut short
    run_frame(PAT_RANDOM, NOISE_NONE, 700, 680);
    wait_idle();

    // directed edge frames; the first runs under a long output hold-off
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    hold_req++;
    run_frame(PAT_CHECKER, NOISE_FORCED, -1, -1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    run_frame(PAT_FULL, NOISE_NONE, -1, -1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    run_frame(PAT_FULL, NOISE_NONE, -1, -1);
    wait_idle();

    // register maximums: width clamps to the line store size
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 65535);
    run_frame(PAT_RANDOM, NOISE_NONE, 1030, -1);
    wait_idle();

    item_count = 0;
    for (int mode = 0; mode < 4; mode++) begin
      idle_pct   = idle_mix[mode];
      stall_pct  = stall_mix[mode];
      mode_start = item_count;
      reconfig   = 1'b1;
      while (item_count - mode_start < MODE_ITEMS) begin
        if (reconfig || $urandom_range(1)) begin
          wait_idle();
          if ($urandom_range(4) == 0) begin
            write_reg(REG_FRAME_WIDTH, $urandom_range(13, 40));
            write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 3));
          end else begin
            write_reg(REG_FRAME_WIDTH, $urandom_range(0, 10));
            write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
          end
        end
        // now and then cut a frame short; the next write restarts it
        stop_at  = ($urandom_range(9) == 0) ? $urandom_range(1, frame_cols * frame_rows) : -1;
        run_frame(PAT_RANDOM, NOISE_RANDOM, stop_at, -1);
        reconfig = (stop_at >= 0);
      end
    end

    in_valid = 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
sv/gb3_pkg.sv
sv/gb3_cfg_regs.sv
sv/gb3_line_store.sv
sv/gb3_kernel.sv
sv/gaussian_blur_3x3_stream_core.sv
dv/blur_checker.sv
dv/tb_top.sv
